// ===== sv/dilp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the delimited integer list parser.
// Word types, register indexes, parser phase and radix codes. No dependencies.
package dilp_pkg;

    localparam int DILP_VALUE_BITS = 64;
    localparam int DILP_CFG_BITS   = 64;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_list;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] value;
        logic               used_default;
        logic [15:0]        position;
        logic               last_in_list;
    } t_out_word;

    typedef enum logic [1:0] {
        CFG_DELIMITER = 2'd0,
        CFG_ESCAPE    = 2'd1,
        CFG_DEFAULT   = 2'd2,
        CFG_MAX_COUNT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef enum logic [6:0] {
        PH_BLANK      = 7'b0000001,
        PH_SIGNED     = 7'b0000010,
        PH_ZERO       = 7'b0000100,
        PH_HEXPFX     = 7'b0001000,
        PH_DIGITS     = 7'b0010000,
        PH_DONE_EMPTY = 7'b0100000,
        PH_DONE_NUM   = 7'b1000000
    } t_phase;

    // Control from the list sequencer to the field parser.
    typedef struct packed {
        logic       feed;
        logic       clear;
        logic [7:0] char_byte;
    } t_field_ctl;

    // Value of the current field, as it would be emitted now.
    typedef struct packed {
        logic signed [63:0] value;
        logic               used_default;
    } t_field_res;

endpackage

// ===== sv/dilp_accum.sv =====
`timescale 1ns / 1ps
// Digit accumulator: magnitude * radix + digit with overflow against 2^(N-1).
// Uses dilp_pkg.
module dilp_accum import dilp_pkg::*; #(
    parameter int VALUE_BITS = DILP_VALUE_BITS
) (
    input  logic [VALUE_BITS-1:0] i_mag,
    input  t_radix                i_radix,
    input  logic [3:0]            i_digit,
    output logic [VALUE_BITS-1:0] o_mag,
    output logic                  o_ovf
);
    localparam int SW = VALUE_BITS + 5;
    localparam logic [SW-1:0] CAP = SW'(1) << (VALUE_BITS - 1);

    logic [SW-1:0] w_mag;
    logic [SW-1:0] w_scaled;
    logic [SW-1:0] w_sum;

    assign w_mag = SW'(i_mag);

    always_comb begin
        case (i_radix)
            RADIX_HEX: w_scaled = w_mag << 4;
            RADIX_OCT: w_scaled = w_mag << 3;
            default:   w_scaled = (w_mag << 3) + (w_mag << 1);
        endcase
    end

    assign w_sum = w_scaled + SW'(i_digit);
    // Stored magnitude never exceeds CAP, so the sum fits in SW bits.
    assign o_ovf = w_sum > CAP;
    assign o_mag = w_sum[VALUE_BITS-1:0];

endmodule

// ===== sv/dilp_field.sv =====
`timescale 1ns / 1ps
// Field parser: strtol-style state (blanks, sign, prefix, digits) and the
// saturated value of the current field. Uses dilp_pkg and dilp_accum.
module dilp_field import dilp_pkg::*; #(
    parameter int VALUE_BITS = DILP_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_field_ctl         i_ctl,
    input  logic signed [63:0] i_default,
    output t_field_res         o_res
);
    localparam logic [VALUE_BITS-1:0] CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [4:0] DIGIT_NONE = 5'd31;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39)      d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
        else                               d = DIGIT_NONE;
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_BS && c <= CH_CR);
    endfunction

    function automatic logic [4:0] digit_limit(input t_radix r);
        logic [4:0] lim;
        case (r)
            RADIX_HEX: lim = 5'd16;
            RADIX_OCT: lim = 5'd8;
            default:   lim = 5'd10;
        endcase
        return lim;
    endfunction

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    t_radix                r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_ovf, n_ovf;

    logic [7:0]            w_c;
    logic [4:0]            w_d;
    logic [VALUE_BITS-1:0] w_acc_mag;
    logic                  w_acc_ovf;
    logic [VALUE_BITS-1:0] w_val;

    assign w_c = i_ctl.char_byte;
    assign w_d = digit_of(w_c);

    dilp_accum #(.VALUE_BITS(VALUE_BITS)) u_accum (
        .i_mag   (r_mag),
        .i_radix (r_radix),
        .i_digit (w_d[3:0]),
        .o_mag   (w_acc_mag),
        .o_ovf   (w_acc_ovf)
    );

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        if (i_ctl.clear) begin
            n_phase = PH_BLANK;
            n_neg   = 1'b0;
            n_radix = RADIX_DEC;
            n_mag   = '0;
            n_ovf   = 1'b0;
        end else if (i_ctl.feed) begin
            case (r_phase)
                PH_BLANK, PH_SIGNED: begin
                    if (r_phase == PH_BLANK && is_blank(w_c)) begin
                        n_phase = PH_BLANK;
                    end else if (r_phase == PH_BLANK && (w_c == CH_PLUS || w_c == CH_MINUS)) begin
                        n_neg   = (w_c == CH_MINUS);
                        n_phase = PH_SIGNED;
                    end else if (w_c == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (w_c >= CH_ONE && w_c <= CH_NINE) begin
                        n_radix = RADIX_DEC;
                        n_mag   = VALUE_BITS'(w_d);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE_EMPTY;
                    end
                end
                PH_ZERO: begin
                    if (w_c == CH_X_LO || w_c == CH_X_UP) begin
                        n_phase = PH_HEXPFX;
                    end else if (w_d < 5'd8) begin
                        n_radix = RADIX_OCT;
                        n_mag   = VALUE_BITS'(w_d);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE_NUM;
                    end
                end
                PH_HEXPFX: begin
                    if (w_d < 5'd16) begin
                        n_radix = RADIX_HEX;
                        n_mag   = VALUE_BITS'(w_d);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE_NUM;
                    end
                end
                PH_DIGITS: begin
                    if (w_d < digit_limit(r_radix)) begin
                        // once saturated the magnitude stays frozen
                        if (!r_ovf) begin
                            if (w_acc_ovf) n_ovf = 1'b1;
                            else           n_mag = w_acc_mag;
                        end
                    end else begin
                        n_phase = PH_DONE_NUM;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_neg   <= 1'b0;
            r_radix <= RADIX_DEC;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_radix <= n_radix;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
        end
    end

    // Negative overflow gives CAP, which reads as the most negative value.
    always_comb begin
        if (r_neg)
            w_val = r_ovf ? CAP : ('0 - r_mag);
        else
            w_val = (r_ovf || r_mag >= CAP) ? (CAP - 1'b1) : r_mag;
    end

    always_comb begin
        o_res.used_default = (r_phase == PH_BLANK) || (r_phase == PH_SIGNED)
                          || (r_phase == PH_DONE_EMPTY);
        o_res.value = o_res.used_default ? i_default : 64'($signed(w_val));
    end

endmodule

// ===== sv/delimited_integer_list_parser_unit.sv =====
`timescale 1ns / 1ps
// Delimited integer list parser: top level with input register, list sequencer
// (escape, delimiter, count limit), config registers and result register.
// Uses dilp_pkg and dilp_field.
//
// Text arrives one byte per word; a word with end_of_list set closes the list.
// Each unescaped delimiter and each end of list yields one result word, parsed
// like strtol with base 0 and saturated to VALUE_BITS bits, until the count
// limit stops the list. The block takes one word per cycle while not stalled,
// and a closing word copies the field value into the result register; each
// character passes from the input register through the field update (a
// shift-add of the magnitude and one compare against the saturation bound)
// into the field registers. Upstream sees stall only while the result
// register is full and stalled. Config writes take effect immediately and
// are meant for idle periods; there is no clearing pass after reset.
module delimited_integer_list_parser_unit import dilp_pkg::*; #(
    parameter int VALUE_BITS = DILP_VALUE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_word                o_out_data,
    input  logic                     i_cfg_we,
    input  t_cfg_index               i_cfg_index,
    input  logic [DILP_CFG_BITS-1:0] i_cfg_data
);
    logic [7:0]         r_delim;
    logic [7:0]         r_esc;
    logic signed [63:0] r_default;
    logic [15:0]        r_max;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    logic        r_esc_pending, n_esc_pending;
    logic [15:0] r_count, n_count;
    logic        r_stopped, n_stopped;

    logic       w_proc;
    logic       w_accept;
    logic       w_esc_on;
    logic       w_emit;
    logic       w_last;
    t_field_ctl w_ctl;
    t_field_res w_res;

    assign w_proc     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_esc_on   = (r_esc != 8'd0) && (r_esc != r_delim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= 8'd44;
            r_esc     <= 8'd92;
            r_default <= '0;
            r_max     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER: r_delim   <= i_cfg_data[7:0];
                CFG_ESCAPE:    r_esc     <= i_cfg_data[7:0];
                CFG_DEFAULT:   r_default <= $signed(i_cfg_data[63:0]);
                CFG_MAX_COUNT: r_max     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_esc_pending   = r_esc_pending;
        n_count         = r_count;
        n_stopped       = r_stopped;
        w_emit          = 1'b0;
        w_last          = 1'b0;
        w_ctl.feed      = 1'b0;
        w_ctl.clear     = 1'b0;
        w_ctl.char_byte = r_in.char_byte;
        if (w_proc) begin
            if (r_stopped) begin
                if (r_in.end_of_list) begin
                    w_ctl.clear   = 1'b1;
                    n_esc_pending = 1'b0;
                    n_count       = '0;
                    n_stopped     = 1'b0;
                end
            end else if (r_in.end_of_list) begin
                w_emit        = 1'b1;
                w_last        = 1'b1;
                w_ctl.clear   = 1'b1;
                n_esc_pending = 1'b0;
                n_count       = '0;
            end else if (r_esc_pending) begin
                n_esc_pending = 1'b0;
                w_ctl.feed    = 1'b1;
            end else if (w_esc_on && r_in.char_byte == r_esc) begin
                n_esc_pending = 1'b1;
            end else if (r_in.char_byte == r_delim) begin
                w_emit      = 1'b1;
                w_last      = (r_max != 16'd0) && ({1'b0, r_count} + 17'd1 >= {1'b0, r_max});
                w_ctl.clear = 1'b1;
                if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
                if (w_last) n_stopped = 1'b1;
            end else begin
                w_ctl.feed = 1'b1;
            end
        end
    end

    dilp_field #(.VALUE_BITS(VALUE_BITS)) u_field (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_default (r_default),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_esc_pending <= 1'b0;
            r_count       <= '0;
            r_stopped     <= 1'b0;
        end else begin
            r_esc_pending <= n_esc_pending;
            r_count       <= n_count;
            r_stopped     <= n_stopped;
            if (w_accept)    r_in_valid <= 1'b1;
            else if (w_proc) r_in_valid <= 1'b0;
            if (w_emit)                            r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_in_data;
        if (w_emit) begin
            r_out.value        <= w_res.value;
            r_out.used_default <= w_res.used_default;
            r_out.position     <= r_count;
            r_out.last_in_list <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a stopped list has emitted at least one word
    a_stopped_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_count != 16'd0)
        else $error("list stopped with zero count");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in.end_of_list |=> r_count == 16'd0 && !r_stopped && !r_esc_pending)
        else $error("end of list did not rearm the parser");

    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in.end_of_list && !r_stopped |=> o_out_valid && o_out_data.last_in_list)
        else $error("end of list gave no final word");

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled without output back-pressure");

endmodule

// ===== dv/delimited_integer_list_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for delimited_integer_list_parser_unit: directed and random text lists,
// checked word by word against an in-bench strtol-style field predictor.
// Depends on dilp_pkg and the parser top level.
module delimited_integer_list_parser_unit_tb;
    import dilp_pkg::*;

    localparam logic [63:0] SAT_BOUND = 64'h1 << (DILP_VALUE_BITS - 1);
    localparam int CYCLE_LIMIT = 300000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_word                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_word                o_out_data;
    logic                     i_cfg_we = 1'b0;
    t_cfg_index               i_cfg_index = CFG_DELIMITER;
    logic [DILP_CFG_BITS-1:0] i_cfg_data = '0;

    delimited_integer_list_parser_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register mirror
    logic [7:0]  cur_delim;
    logic [7:0]  cur_escape;
    logic [63:0] cur_default;
    logic [15:0] cur_max_count;

    // parser mirror
    bit          esc_armed;
    t_phase      fld_phase;
    bit          fld_neg;
    t_radix      fld_radix;
    logic [63:0] fld_mag;
    bit          fld_ovf;
    logic [15:0] list_count;
    bit          list_halted;

    t_out_word   expected_values[$];
    t_out_word   want;
    bit [7:0]    list_text[$];
    int          live_words = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    function automatic int char_digit(input bit [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 99;
    endfunction

    function automatic bit is_blank(input bit [7:0] c);
        return c == 8'h20 || (c >= 8'h08 && c <= 8'h0D);
    endfunction

    function void clear_field();
        fld_phase = PH_BLANK;
        fld_neg   = 1'b0;
        fld_radix = RADIX_DEC;
        fld_mag   = '0;
        fld_ovf   = 1'b0;
    endfunction

    function void clear_list();
        clear_field();
        esc_armed   = 1'b0;
        list_count  = '0;
        list_halted = 1'b0;
    endfunction

    function void feed_char(input bit [7:0] c);
        int          d;
        bit          first_digit;
        logic [63:0] base;
        d = char_digit(c);
        first_digit = 1'b0;
        base = (fld_radix == RADIX_HEX) ? 64'd16 : (fld_radix == RADIX_OCT) ? 64'd8 : 64'd10;
        case (fld_phase)
            PH_BLANK: begin
                if (c == "+" || c == "-") begin
                    fld_neg = (c == "-");
                    fld_phase = PH_SIGNED;
                end else if (!is_blank(c)) begin
                    first_digit = 1'b1;
                end
            end
            PH_SIGNED: first_digit = 1'b1;
            PH_ZERO: begin
                if (c == "x" || c == "X") begin
                    fld_phase = PH_HEXPFX;
                end else if (d < 8) begin
                    fld_radix = RADIX_OCT;
                    fld_mag = 64'(d);
                    fld_phase = PH_DIGITS;
                end else begin
                    fld_phase = PH_DONE_NUM;
                end
            end
            PH_HEXPFX: begin
                if (d < 16) begin
                    fld_radix = RADIX_HEX;
                    fld_mag = 64'(d);
                    fld_phase = PH_DIGITS;
                end else begin
                    fld_phase = PH_DONE_NUM;
                end
            end
            PH_DIGITS: begin
                if (d >= int'(base)) begin
                    fld_phase = PH_DONE_NUM;
                end else if (!fld_ovf) begin
                    // magnitude freezes once it would pass the saturation bound
                    if (fld_mag > (SAT_BOUND - 64'(d)) / base) fld_ovf = 1'b1;
                    else fld_mag = fld_mag * base + 64'(d);
                end
            end
            default: ;
        endcase
        if (first_digit) begin
            if (c == "0") begin
                fld_phase = PH_ZERO;
            end else if (c >= "1" && c <= "9") begin
                fld_radix = RADIX_DEC;
                fld_mag = 64'(d);
                fld_phase = PH_DIGITS;
            end else begin
                fld_phase = PH_DONE_EMPTY;
            end
        end
    endfunction

    function void close_field(input bit last);
        t_out_word r;
        r.used_default = 1'b0;
        if (fld_phase == PH_BLANK || fld_phase == PH_SIGNED || fld_phase == PH_DONE_EMPTY) begin
            r.value = cur_default;
            r.used_default = 1'b1;
        end else if (fld_neg) begin
            r.value = 64'd0 - (fld_ovf ? SAT_BOUND : fld_mag);
        end else begin
            r.value = (fld_ovf || fld_mag >= SAT_BOUND) ? SAT_BOUND - 64'd1 : fld_mag;
        end
        r.position = list_count;
        r.last_in_list = last;
        expected_values.push_back(r);
        if (list_count != 16'hFFFF) list_count++;
        clear_field();
    endfunction

    // predicts the result word, if any, caused by one accepted input word
    function void parse_word(input t_in_word w);
        bit esc_on;
        bit last;
        esc_on = cur_escape != 8'h00 && cur_escape != cur_delim;
        live_words++;
        if (list_halted) begin
            if (w.end_of_list) clear_list();
        end else begin
            if (w.end_of_list) begin
                close_field(1'b1);
                clear_list();
            end else if (esc_armed) begin
                esc_armed = 1'b0;
                feed_char(w.char_byte);
            end else if (esc_on && w.char_byte == cur_escape) begin
                esc_armed = 1'b1;
            end else if (w.char_byte == cur_delim) begin
                last = cur_max_count != 16'd0 &&
                       {16'd0, list_count} + 32'd1 >= {16'd0, cur_max_count};
                close_field(last);
                if (last) list_halted = 1'b1;
            end else begin
                feed_char(w.char_byte);
            end
        end
    endfunction

    task send_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_word(w);
        @(negedge i_clk);
    endtask

    task send_char(input bit [7:0] c);
        send_word('{char_byte: c, end_of_list: 1'b0});
    endtask

    task send_end();
        send_word('{char_byte: 8'($urandom), end_of_list: 1'b1});
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // drains results and lets words that cause none clear the pipeline
    task wait_idle();
        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task write_reg(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DELIMITER: cur_delim = data[7:0];
            CFG_ESCAPE:    cur_escape = data[7:0];
            CFG_DEFAULT:   cur_default = data;
            CFG_MAX_COUNT: cur_max_count = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function bit [7:0] blank_byte();
        case ($urandom_range(0, 6))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h08;
            3: return 8'h0A;
            4: return 8'h0B;
            5: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function bit [7:0] hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    function void add_field();
        int n;
        repeat ($urandom_range(0, 2)) list_text.push_back(blank_byte());
        case ($urandom_range(0, 3))
            0: list_text.push_back("+");
            1: list_text.push_back("-");
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
                list_text.push_back(8'($urandom_range(49, 57)));
                repeat (n - 1) list_text.push_back(8'($urandom_range(48, 57)));
            end
            4, 5: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
                list_text.push_back("0");
                list_text.push_back($urandom_range(0, 1) ? "x" : "X");
                repeat (n) list_text.push_back(hex_char());
            end
            6, 7: begin
                n = $urandom_range(0, 23);
                list_text.push_back("0");
                repeat (n) list_text.push_back(8'($urandom_range(48, 55)));
            end
            8: ;
            default: repeat ($urandom_range(1, 3)) list_text.push_back(8'($urandom));
        endcase
        if ($urandom_range(0, 4) == 0) list_text.push_back(8'($urandom));
    endfunction

    task send_random_list();
        int fields;
        bit esc_on;
        list_text.delete();
        esc_on = cur_escape != 8'h00 && cur_escape != cur_delim;
        fields = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) list_text.push_back(8'($urandom));
        end else begin
            for (int f = 0; f < fields; f++) begin
                if (f != 0) list_text.push_back(cur_delim);
                add_field();
            end
        end
        if ($urandom_range(0, 5) == 0) list_text.push_back(cur_delim);
        foreach (list_text[i]) begin
            if (esc_on && $urandom_range(0, 19) == 0) send_char(cur_escape);
            send_char(list_text[i]);
        end
        if (esc_on && $urandom_range(0, 15) == 0) send_char(cur_escape);
        send_end();
    endtask

    task reconfigure();
        logic [7:0]  delim;
        logic [7:0]  esc;
        logic [63:0] dflt;
        logic [15:0] limit;
        wait_idle();
        case ($urandom_range(0, 7))
            0, 1, 2: delim = ",";
            3: delim = 8'h00;
            4: delim = 8'hFF;
            5: delim = ";";
            6: delim = " ";
            default: delim = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0, 1: esc = "\\";
            2: esc = 8'h00;
            3: esc = delim;
            4: esc = 8'hFF;
            default: esc = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: dflt = 64'h8000_0000_0000_0000;
            1: dflt = 64'h7FFF_FFFF_FFFF_FFFF;
            2: dflt = '0;
            default: dflt = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2, 3: limit = 16'd0;
            4: limit = 16'd1;
            5: limit = 16'hFFFF;
            default: limit = 16'($urandom_range(2, 6));
        endcase
        // upper bits beyond each register's width are junk on purpose
        write_reg(CFG_DELIMITER, {$urandom, 24'($urandom), delim});
        write_reg(CFG_ESCAPE, {$urandom, 24'($urandom), esc});
        write_reg(CFG_DEFAULT, dflt);
        write_reg(CFG_MAX_COUNT, {$urandom, 16'($urandom), limit});
    endtask

    // blanks, signs, hex/octal prefixes with no digits, blank after sign, zero byte
    task test_field_forms();
        send_text(" \t-0x,08,+ 3,");
        send_char(8'h00);
        send_text(",0X1f");
        send_end();
        send_end();
    endtask

    task test_escape_rules();
        wait_idle();
        write_reg(CFG_DEFAULT, 64'h8000_0000_0000_0000);
        // escaped delimiter stays in the field; trailing escape is dropped
        send_text("\\,7\\");
        send_end();
        // pending escape survives escaping being switched off
        send_char("\\");
        wait_idle();
        write_reg(CFG_ESCAPE, 64'd0);
        send_text(",9");
        send_end();
        wait_idle();
        write_reg(CFG_ESCAPE, 64'd92);
    endtask

    task test_overflow();
        send_text("-0x80000000000000001");
        send_char(8'hFF);
        send_text(",0x8000000000000000");
        send_end();
    endtask

    task test_count_limit();
        wait_idle();
        write_reg(CFG_MAX_COUNT, 64'd2);
        send_text("1,2,3");
        send_end();
        wait_idle();
        write_reg(CFG_MAX_COUNT, 64'd0);
        send_text("4,5,");
        // limit dropped below what this list already emitted
        wait_idle();
        write_reg(CFG_MAX_COUNT, 64'd1);
        send_text("6,7");
        send_end();
        wait_idle();
        write_reg(CFG_MAX_COUNT, 64'd0);
        write_reg(CFG_DELIMITER, 64'd0);
        send_char("5");
        send_char(8'h00);
        send_char("6");
        send_end();
        wait_idle();
        write_reg(CFG_DELIMITER, 64'd44);
    endtask

    task test_random_lists(input int word_target, input bit with_idle);
        int start;
        start = live_words;
        reconfigure();
        while (live_words - start < word_target) begin
            if ($urandom_range(0, 7) == 0) reconfigure();
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            send_random_list();
        end
        idle_on = with_idle;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
        i_out_stall <= idle_on && (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value=%0d dflt=%0b pos=%0d last=%0b",
                             o_out_data.value, o_out_data.used_default,
                             o_out_data.position, o_out_data.last_in_list);
            end else begin
                want = expected_values.pop_front();
                if (o_out_data.value !== want.value ||
                    o_out_data.used_default !== want.used_default ||
                    o_out_data.position !== want.position ||
                    o_out_data.last_in_list !== want.last_in_list) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp value=%0d dflt=%0b pos=%0d last=%0b",
                               want.value, want.used_default, want.position,
                               want.last_in_list);
                        $display(" got value=%0d dflt=%0b pos=%0d last=%0b",
                                 o_out_data.value, o_out_data.used_default,
                                 o_out_data.position, o_out_data.last_in_list);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("delimited_integer_list_parser_unit test failed");
        $finish;
    end

    initial begin
        cur_delim = 8'd44;
        cur_escape = 8'd92;
        cur_default = '0;
        cur_max_count = '0;
        clear_list();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        test_field_forms();
        test_escape_rules();
        test_overflow();
        test_count_limit();
        test_random_lists(1000, 1'b1);
        test_random_lists(150, 1'b0);
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("delimited_integer_list_parser_unit test passed");
        else
            $display("delimited_integer_list_parser_unit test failed");
        $finish;
    end

endmodule
